### hdl/haversine_distance_macros.svh
// Assertion macros shared by the haversine distance RTL.
// Both macros assume a clock named clk and an active-low reset named rst_n.
`ifndef HAVERSINE_DISTANCE_MACROS_SVH
`define HAVERSINE_DISTANCE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HD_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("haversine_distance check failed");

// The consequent must hold in the cycle after the antecedent.
`define HD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("haversine_distance check failed");

`endif

### hdl/hd_pkg.sv
// Constants, types and the arctangent table of the haversine distance pipeline.
// No dependencies; used by haversine_distance.
package hd_pkg;

    // CORDIC length and angle format (radians, 30 fraction bits).
    localparam int CORDIC_STEPS = 24;
    localparam int FRAC_BITS    = 30;
    localparam int SQRT_STEPS   = 32;

    // Widths of the internal words.
    localparam int ANG_W = 36;
    localparam int CS_W  = 34;
    localparam int VEC_W = 50;

    typedef logic signed [ANG_W-1:0] angle_t;
    typedef logic signed [CS_W-1:0]  cs_t;
    typedef logic signed [VEC_W-1:0] vec_t;

    // Degree (1e-7) to radian factor with 60 fraction bits.
    localparam logic [30:0] DEG_TO_RAD = 31'd2012227627;

    localparam angle_t PI_F      = 36'sd3373259426;
    localparam angle_t HALF_PI_F = 36'sd1686629713;
    localparam angle_t TWO_PI_F  = 36'sd6746518852;

    // Inverse CORDIC gain and unity in the angle format.
    localparam cs_t         GAIN_INV = 34'sd652032874;
    localparam logic [30:0] ONE_F    = 31'd1073741824;

    localparam logic [30:0] DIST_MAX     = 31'd1647099000;
    localparam logic [28:0] RADIUS_RESET = 29'd417529856;

    // Arctangent of 2^-i in the angle format.
    function automatic angle_t atan_value(input int i);
        angle_t v;
        case (i)
            0:       v = 36'sd843314857;
            1:       v = 36'sd497837829;
            2:       v = 36'sd263043837;
            3:       v = 36'sd133525159;
            4:       v = 36'sd67021687;
            5:       v = 36'sd33543516;
            6:       v = 36'sd16775851;
            7:       v = 36'sd8388437;
            8:       v = 36'sd4194283;
            9:       v = 36'sd2097149;
            default: v = angle_t'(36'sd1 <<< (FRAC_BITS - i));
        endcase
        return v;
    endfunction

endpackage

### hdl/haversine_distance.sv
// Each result is presented on distance with done high for one cycle.
// One coordinate pair per cycle; busy is never raised and results are never held.
// The pipeline holds two unrolled 24-step CORDICs and a 32-step square root.
// Reset (rst_n low, asynchronous) empties the pipeline and restores the 6371 km radius.
// The radius register is taken at any time on cfg_valid; cfg_ready is always high.
module haversine_distance
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic signed [30:0] first_lat,
    input  logic signed [31:0] first_lon,
    input  logic signed [30:0] second_lat,
    input  logic signed [31:0] second_lon,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [28:0] cfg_data,
    output logic        done,
    output logic [30:0] distance
);
    import hd_pkg::*;

    `include "haversine_distance_macros.svh"

    // Handshake: the pipeline never stalls.
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Radius register.
    logic [28:0] radius_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radius_reg <= RADIUS_RESET;
        else if (cfg_valid && cfg_ready)
            radius_reg <= cfg_data;
    end

    // Input stage: coordinates sign extended to 32 bits.
    logic              in_v_reg;
    logic signed [31:0] coord_reg [0:3];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_v_reg <= 1'b0;
        else
            in_v_reg <= start && !busy;
    end
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            coord_reg[0] <= 32'(first_lat);
            coord_reg[1] <= 32'(first_lon);
            coord_reg[2] <= 32'(second_lat);
            coord_reg[3] <= 32'(second_lon);
        end
    end

    // Conversion multiply on the magnitudes.
    logic        mul_v_reg;
    logic [62:0] conv_reg [0:3];
    logic [62:0] conv_next [0:3];
    logic        neg_reg [0:3];
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            logic [31:0] mag;
            mag = coord_reg[k][31] ? 32'(-coord_reg[k]) : 32'(coord_reg[k]);
            conv_next[k] = 63'(mag) * 63'(DEG_TO_RAD);
        end
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mul_v_reg <= 1'b0;
        else
            mul_v_reg <= in_v_reg;
    end
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
        begin
            conv_reg[k] <= conv_next[k];
            neg_reg[k]  <= coord_reg[k][31];
        end
    end

    // Round to the angle format and restore the sign.
    logic   rad_v_reg;
    angle_t rad_reg [0:3];
    angle_t rad_next [0:3];
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            logic [62:0] rnd;
            rnd = (conv_reg[k] + (63'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
            rad_next[k] = neg_reg[k] ? -angle_t'(rnd[32:0]) : angle_t'(rnd[32:0]);
        end
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rad_v_reg <= 1'b0;
        else
            rad_v_reg <= mul_v_reg;
    end
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
            rad_reg[k] <= rad_next[k];
    end

    // Half differences; lanes: half dlat, half dlon, lat1, lat2.
    logic   ang_v_reg;
    angle_t ang_reg [0:3];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ang_v_reg <= 1'b0;
        else
            ang_v_reg <= rad_v_reg;
    end
    always_ff @(posedge clk)
    begin
        ang_reg[0] <= (rad_reg[2] - rad_reg[0]) >>> 1;
        ang_reg[1] <= (rad_reg[3] - rad_reg[1]) >>> 1;
        ang_reg[2] <= rad_reg[0];
        ang_reg[3] <= rad_reg[2];
    end

    // Rotation CORDIC, four lanes; stage 0 holds the wrapped and folded angles.
    logic   rot_v_reg [0:CORDIC_STEPS];
    cs_t    rot_x_reg [0:CORDIC_STEPS][0:3];
    cs_t    rot_y_reg [0:CORDIC_STEPS][0:3];
    angle_t rot_z_reg [0:CORDIC_STEPS][0:3];
    logic   rot_n_reg [0:CORDIC_STEPS][0:3];
    angle_t fold_z_next [0:3];
    logic   fold_n_next [0:3];

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            angle_t w;
            w = ang_reg[k];
            if (w > PI_F)
                w = w - TWO_PI_F;
            else if (w < -PI_F)
                w = w + TWO_PI_F;
            fold_n_next[k] = 1'b0;
            if (w > HALF_PI_F)
            begin
                w = PI_F - w;
                fold_n_next[k] = 1'b1;
            end
            else if (w < -HALF_PI_F)
            begin
                w = -PI_F - w;
                fold_n_next[k] = 1'b1;
            end
            fold_z_next[k] = w;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rot_v_reg[0] <= 1'b0;
        else
            rot_v_reg[0] <= ang_v_reg;
    end
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
        begin
            rot_x_reg[0][k] <= GAIN_INV;
            rot_y_reg[0][k] <= '0;
            rot_z_reg[0][k] <= fold_z_next[k];
            rot_n_reg[0][k] <= fold_n_next[k];
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_rot
        cs_t    x_next [0:3];
        cs_t    y_next [0:3];
        angle_t z_next [0:3];
        always_comb
        begin
            for (int k = 0; k < 4; k++)
            begin
                if (!rot_z_reg[i][k][ANG_W-1])
                begin
                    x_next[k] = rot_x_reg[i][k] - (rot_y_reg[i][k] >>> i);
                    y_next[k] = rot_y_reg[i][k] + (rot_x_reg[i][k] >>> i);
                    z_next[k] = rot_z_reg[i][k] - atan_value(i);
                end
                else
                begin
                    x_next[k] = rot_x_reg[i][k] + (rot_y_reg[i][k] >>> i);
                    y_next[k] = rot_y_reg[i][k] - (rot_x_reg[i][k] >>> i);
                    z_next[k] = rot_z_reg[i][k] + atan_value(i);
                end
            end
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                rot_v_reg[i+1] <= 1'b0;
            else
                rot_v_reg[i+1] <= rot_v_reg[i];
        end
        always_ff @(posedge clk)
        begin
            for (int k = 0; k < 4; k++)
            begin
                rot_x_reg[i+1][k] <= x_next[k];
                rot_y_reg[i+1][k] <= y_next[k];
                rot_z_reg[i+1][k] <= z_next[k];
                rot_n_reg[i+1][k] <= rot_n_reg[i][k];
            end
        end
    end

    // Products: sin^2(dlat/2), cos(lat1)cos(lat2), sin^2(dlon/2).
    function automatic angle_t smul_f(input cs_t a, input cs_t b);
        logic [CS_W-1:0] ma;
        logic [CS_W-1:0] mb;
        logic [67:0]     p;
        logic [67:0]     r;
        ma = a[CS_W-1] ? CS_W'(-a) : CS_W'(a);
        mb = b[CS_W-1] ? CS_W'(-b) : CS_W'(b);
        p  = 68'(ma) * 68'(mb);
        r  = (p + (68'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        return (a[CS_W-1] != b[CS_W-1]) ? -angle_t'(r[ANG_W-1:0]) : angle_t'(r[ANG_W-1:0]);
    endfunction

    cs_t  c1_w;
    cs_t  c2_w;
    logic prod_v_reg;
    cs_t  sq1_reg;
    cs_t  cc_reg;
    cs_t  sq2_reg;
    assign c1_w = rot_n_reg[CORDIC_STEPS][2] ? -rot_x_reg[CORDIC_STEPS][2]
                                             : rot_x_reg[CORDIC_STEPS][2];
    assign c2_w = rot_n_reg[CORDIC_STEPS][3] ? -rot_x_reg[CORDIC_STEPS][3]
                                             : rot_x_reg[CORDIC_STEPS][3];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prod_v_reg <= 1'b0;
        else
            prod_v_reg <= rot_v_reg[CORDIC_STEPS];
    end
    always_ff @(posedge clk)
    begin
        sq1_reg <= CS_W'(smul_f(rot_y_reg[CORDIC_STEPS][0], rot_y_reg[CORDIC_STEPS][0]));
        cc_reg  <= CS_W'(smul_f(c1_w, c2_w));
        sq2_reg <= CS_W'(smul_f(rot_y_reg[CORDIC_STEPS][1], rot_y_reg[CORDIC_STEPS][1]));
    end

    // Sum into a.
    logic   sum_v_reg;
    angle_t sum_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sum_v_reg <= 1'b0;
        else
            sum_v_reg <= prod_v_reg;
    end
    always_ff @(posedge clk)
    begin
        sum_reg <= angle_t'(sq1_reg) + smul_f(cc_reg, sq2_reg);
    end

    // Clamp a to [0, 1] and form 1 - a; these seed the two square roots.
    logic        a_v_reg;
    logic [30:0] a_reg;
    logic [30:0] a_next;
    always_comb
    begin
        if (sum_reg[ANG_W-1])
            a_next = '0;
        else if (sum_reg > angle_t'(ONE_F))
            a_next = ONE_F;
        else
            a_next = sum_reg[30:0];
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_v_reg <= 1'b0;
        else
            a_v_reg <= sum_v_reg;
    end
    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
    end

    // Digit-by-digit square roots of a and 1 - a, both shifted left by 32.
    logic        sq_v_reg   [0:SQRT_STEPS];
    logic [63:0] sq_n_reg   [0:SQRT_STEPS][0:1];
    logic [33:0] sq_rem_reg [0:SQRT_STEPS][0:1];
    logic [31:0] sq_root_reg[0:SQRT_STEPS][0:1];
    assign sq_v_reg[0]       = a_v_reg;
    assign sq_n_reg[0][0]    = {1'b0, a_reg, 32'd0};
    assign sq_n_reg[0][1]    = {1'b0, ONE_F - a_reg, 32'd0};
    assign sq_rem_reg[0][0]  = '0;
    assign sq_rem_reg[0][1]  = '0;
    assign sq_root_reg[0][0] = '0;
    assign sq_root_reg[0][1] = '0;

    for (genvar j = 0; j < SQRT_STEPS; j++)
    begin : g_sqrt
        logic [33:0] rem_next  [0:1];
        logic [31:0] root_next [0:1];
        always_comb
        begin
            for (int k = 0; k < 2; k++)
            begin
                logic [35:0] trial_rem;
                logic [35:0] trial;
                trial_rem = {sq_rem_reg[j][k], sq_n_reg[j][k][63:62]};
                trial     = {2'b00, sq_root_reg[j][k], 2'b01};
                if (trial_rem >= trial)
                begin
                    rem_next[k]  = 34'(trial_rem - trial);
                    root_next[k] = {sq_root_reg[j][k][30:0], 1'b1};
                end
                else
                begin
                    rem_next[k]  = trial_rem[33:0];
                    root_next[k] = {sq_root_reg[j][k][30:0], 1'b0};
                end
            end
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_v_reg[j+1] <= 1'b0;
            else
                sq_v_reg[j+1] <= sq_v_reg[j];
        end
        always_ff @(posedge clk)
        begin
            for (int k = 0; k < 2; k++)
            begin
                sq_n_reg[j+1][k]    <= {sq_n_reg[j][k][61:0], 2'b00};
                sq_rem_reg[j+1][k]  <= rem_next[k];
                sq_root_reg[j+1][k] <= root_next[k];
            end
        end
    end

    // Vectoring CORDIC: central half angle from (sqrt(1-a), sqrt(a)).
    logic   vec_v_reg [0:CORDIC_STEPS];
    vec_t   vec_x_reg [0:CORDIC_STEPS];
    vec_t   vec_y_reg [0:CORDIC_STEPS];
    angle_t vec_z_reg [0:CORDIC_STEPS];
    assign vec_v_reg[0] = sq_v_reg[SQRT_STEPS];
    assign vec_x_reg[0] = vec_t'({sq_root_reg[SQRT_STEPS][1], 16'd0});
    assign vec_y_reg[0] = vec_t'({sq_root_reg[SQRT_STEPS][0], 16'd0});
    assign vec_z_reg[0] = '0;

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_vec
        vec_t   x_next;
        vec_t   y_next;
        angle_t z_next;
        always_comb
        begin
            if (!vec_y_reg[i][VEC_W-1])
            begin
                x_next = vec_x_reg[i] + (vec_y_reg[i] >>> i);
                y_next = vec_y_reg[i] - (vec_x_reg[i] >>> i);
                z_next = vec_z_reg[i] + atan_value(i);
            end
            else
            begin
                x_next = vec_x_reg[i] - (vec_y_reg[i] >>> i);
                y_next = vec_y_reg[i] + (vec_x_reg[i] >>> i);
                z_next = vec_z_reg[i] - atan_value(i);
            end
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vec_v_reg[i+1] <= 1'b0;
            else
                vec_v_reg[i+1] <= vec_v_reg[i];
        end
        always_ff @(posedge clk)
        begin
            vec_x_reg[i+1] <= x_next;
            vec_y_reg[i+1] <= y_next;
            vec_z_reg[i+1] <= z_next;
        end
    end

    // Scale the clamped angle by the radius.
    logic        scale_v_reg;
    logic [61:0] scale_reg;
    logic [32:0] zc_w;
    assign zc_w = vec_z_reg[CORDIC_STEPS][ANG_W-1] ? '0 : vec_z_reg[CORDIC_STEPS][32:0];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scale_v_reg <= 1'b0;
        else
            scale_v_reg <= vec_v_reg[CORDIC_STEPS];
    end
    always_ff @(posedge clk)
    begin
        scale_reg <= 62'(zc_w) * 62'(radius_reg);
    end

    // Round, saturate and present the result beat.
    logic [61:0] dist_w;
    logic        done_reg;
    logic [30:0] distance_reg;
    logic [30:0] distance_next;
    assign dist_w = (scale_reg + (62'd1 << (FRAC_BITS - 2))) >> (FRAC_BITS - 1);
    assign distance_next = (dist_w > 62'(DIST_MAX)) ? DIST_MAX : dist_w[30:0];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= scale_v_reg;
    end
    always_ff @(posedge clk)
    begin
        distance_reg <= distance_next;
    end
    assign done     = done_reg;
    assign distance = distance_reg;

    // Checks on the pipeline.
    `HD_ASSERT_IMPL(a_in_range, a_v_reg, a_reg <= ONE_F)
    `HD_ASSERT_IMPL(dist_saturated, done, distance <= DIST_MAX)
    `HD_ASSERT_NEXT(start_enters, start && !busy, in_v_reg)
    `HD_ASSERT_NEXT(scale_to_done, scale_v_reg, done)

endmodule
